// File: rtl/tcps_pkg.sv
// ----------------------------------------------------------------------------
// tcps_pkg
// Shared types, byte codes and option table for the telnet com-port parser.
// ----------------------------------------------------------------------------
package tcps_pkg;

    localparam int SUB_DEPTH_DEFAULT = 16;
    localparam int NUM_BUF           = 6;
    localparam int NUM_ENTRIES       = 7;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [7:0] B_IAC     = 8'hff;
    localparam logic [7:0] B_SB      = 8'hfa;
    localparam logic [7:0] B_SE      = 8'hf0;
    localparam logic [7:0] B_WILL    = 8'hfb;
    localparam logic [7:0] B_WONT    = 8'hfc;
    localparam logic [7:0] B_DO      = 8'hfd;
    localparam logic [7:0] B_DONT    = 8'hfe;
    localparam logic [7:0] B_COMPORT = 8'h2c;

    localparam logic [7:0] CMD_BAUD    = 8'h01;
    localparam logic [7:0] CMD_DATA    = 8'h02;
    localparam logic [7:0] CMD_PARITY  = 8'h03;
    localparam logic [7:0] CMD_STOP    = 8'h04;
    localparam logic [7:0] CMD_CONTROL = 8'h05;
    localparam logic [7:0] CMD_NOTIFY  = 8'h06;
    localparam logic [7:0] CMD_MASK    = 8'h07;
    localparam logic [7:0] CMD_PURGE   = 8'h0c;

    localparam logic [7:0] RPL_BAUD    = 8'h65;
    localparam logic [7:0] RPL_CONTROL = 8'h69;
    localparam logic [7:0] RPL_PURGE   = 8'h70;
    localparam logic [7:0] RPL_BASE    = 8'h64;

    localparam logic [1:0] OUT_DATA  = 2'd0;
    localparam logic [1:0] OUT_REPLY = 2'd1;
    localparam logic [1:0] OUT_EVENT = 2'd2;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_CAPABLE = 3'd1;
    localparam logic [2:0] EV_BAUD    = 3'd2;
    localparam logic [2:0] EV_CONTROL = 3'd3;
    localparam logic [2:0] EV_PURGE   = 3'd4;

    localparam logic [1:0] ST_REQ    = 2'd0;
    localparam logic [1:0] ST_ACT    = 2'd1;
    localparam logic [1:0] ST_INACT  = 2'd2;
    localparam logic [1:0] ST_REALLY = 2'd3;

    localparam logic [7:0] ENT_OPT [NUM_ENTRIES] =
        '{8'h01, 8'h03, 8'h03, 8'h00, 8'h00, B_COMPORT, B_COMPORT};
    localparam logic [1:0] ENT_INIT [NUM_ENTRIES] =
        '{ST_REQ, ST_REQ, ST_INACT, ST_INACT, ST_REQ, ST_REQ, ST_INACT};
    localparam logic [7:0] ENT_YES_SEND [NUM_ENTRIES] =
        '{B_WILL, B_WILL, B_DO, B_WILL, B_DO, B_WILL, B_DO};
    localparam logic [7:0] ENT_NO_SEND [NUM_ENTRIES] =
        '{B_WONT, B_WONT, B_DONT, B_WONT, B_DONT, B_WONT, B_DONT};
    localparam logic [7:0] ENT_YES_ACK [NUM_ENTRIES] =
        '{B_DO, B_DO, B_WILL, B_DO, B_WILL, B_DO, B_WILL};
    localparam logic [7:0] ENT_NO_ACK [NUM_ENTRIES] =
        '{B_DONT, B_DONT, B_WONT, B_DONT, B_WONT, B_DONT, B_WONT};
    localparam logic ENT_COMPORT [NUM_ENTRIES] =
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_IAC,
        MODE_NEG
    } mode_t;

    typedef enum logic [1:0] {
        JOB_DATA,
        JOB_NEG,
        JOB_SUB
    } job_kind_t;

    typedef enum logic [1:0] {
        SUB_BAUD,
        SUB_CTRL,
        SUB_PURGE,
        SUB_OTHER
    } sub_kind_t;

    typedef enum logic [2:0] {
        BK_SERIAL,
        BK_OPT,
        BK_CAP,
        BK_EV,
        BK_HDR,
        BK_DATA,
        BK_TAIL
    } back_state_t;

    typedef struct packed {
        job_kind_t       kind;
        sub_kind_t       sub;
        logic [7:0]      b0;
        logic [7:0]      verb;
        logic            send3;
        logic            cap_ev;
        logic [3:0][7:0] data;
    } job_t;

    typedef struct packed {
        logic       op;
        logic [7:0] in_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic [2:0]  event_code;
        logic [31:0] event_value;
        logic        last;
    } out_t;

endpackage

// File: rtl/tcps_front.sv
// ----------------------------------------------------------------------------
// tcps_front
// Parses the telnet byte stream, keeps session state and issues jobs.
// ----------------------------------------------------------------------------
module tcps_front #(
    parameter int SUB_DEPTH = tcps_pkg::SUB_DEPTH_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tcps_pkg::in_t  s_data,
    input  logic           q_full,
    output logic           push,
    output tcps_pkg::job_t job
);

    localparam int CNT_W = $clog2(SUB_DEPTH + 1);

    tcps_pkg::mode_t mode_reg, mode_next;
    logic            coll_reg, coll_next;
    logic [7:0]      verb_reg, verb_next;
    logic [7:0]      buf_reg [tcps_pkg::NUM_BUF];
    logic [7:0]      buf_next [tcps_pkg::NUM_BUF];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]      st_reg [tcps_pkg::NUM_ENTRIES];
    logic [1:0]      st_next [tcps_pkg::NUM_ENTRIES];
    logic            cap_reg, cap_next;

    logic       acc;
    logic [7:0] c;
    logic       take;
    logic       known;
    logic       snd;
    logic [7:0] sv;
    logic       trig;

    assign s_ready = !q_full;
    assign acc     = s_valid && s_ready;
    assign c       = s_data.in_byte;

    always_comb begin
        mode_next = mode_reg;
        coll_next = coll_reg;
        verb_next = verb_reg;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        st_next   = st_reg;
        cap_next  = cap_reg;
        push      = 1'b0;
        job       = '0;
        take      = 1'b0;
        known     = 1'b0;
        snd       = 1'b0;
        sv        = '0;
        trig      = 1'b0;
        if (acc) begin
            if (s_data.op) begin
                mode_next = tcps_pkg::MODE_NORMAL;
                coll_next = 1'b0;
                cnt_next  = '0;
                cap_next  = 1'b0;
                for (int i = 0; i < tcps_pkg::NUM_ENTRIES; i++) begin
                    st_next[i] = tcps_pkg::ENT_INIT[i];
                end
            end else begin
                unique case (mode_reg)
                    tcps_pkg::MODE_IAC: begin
                        mode_next = tcps_pkg::MODE_NORMAL;
                        if (c == tcps_pkg::B_IAC) begin
                            take = 1'b1;
                        end else if (c == tcps_pkg::B_SB) begin
                            cnt_next  = '0;
                            coll_next = 1'b1;
                        end else if (c == tcps_pkg::B_SE) begin
                            cnt_next  = '0;
                            coll_next = 1'b0;
                            job.kind  = tcps_pkg::JOB_SUB;
                            job.data[0] = buf_reg[2];
                            job.data[1] = buf_reg[3];
                            job.data[2] = buf_reg[4];
                            job.data[3] = buf_reg[5];
                            if (buf_reg[0] == tcps_pkg::B_COMPORT) begin
                                priority if (buf_reg[1] == tcps_pkg::CMD_BAUD) begin
                                    job.sub = tcps_pkg::SUB_BAUD;
                                    job.b0  = tcps_pkg::RPL_BAUD;
                                    push    = 1'b1;
                                end else if (buf_reg[1] == tcps_pkg::CMD_CONTROL) begin
                                    job.sub = tcps_pkg::SUB_CTRL;
                                    job.b0  = tcps_pkg::RPL_CONTROL;
                                    push    = 1'b1;
                                end else if (buf_reg[1] == tcps_pkg::CMD_PURGE) begin
                                    job.sub = tcps_pkg::SUB_PURGE;
                                    job.b0  = tcps_pkg::RPL_PURGE;
                                    push    = 1'b1;
                                end else if (buf_reg[1] == tcps_pkg::CMD_DATA
                                        || buf_reg[1] == tcps_pkg::CMD_PARITY
                                        || buf_reg[1] == tcps_pkg::CMD_STOP
                                        || buf_reg[1] == tcps_pkg::CMD_NOTIFY
                                        || buf_reg[1] == tcps_pkg::CMD_MASK) begin
                                    job.sub = tcps_pkg::SUB_OTHER;
                                    job.b0  = tcps_pkg::RPL_BASE + buf_reg[1];
                                    push    = 1'b1;
                                end else begin
                                    push    = 1'b0;
                                end
                            end
                        end else if (c == tcps_pkg::B_WILL || c == tcps_pkg::B_WONT
                                || c == tcps_pkg::B_DO || c == tcps_pkg::B_DONT) begin
                            verb_next = c;
                            mode_next = tcps_pkg::MODE_NEG;
                        end
                    end
                    tcps_pkg::MODE_NEG: begin
                        mode_next = tcps_pkg::MODE_NORMAL;
                        for (int i = 0; i < tcps_pkg::NUM_ENTRIES; i++) begin
                            if (tcps_pkg::ENT_OPT[i] == c) begin
                                known = 1'b1;
                                if (verb_reg == tcps_pkg::ENT_YES_ACK[i]) begin
                                    if (st_reg[i] == tcps_pkg::ST_REQ) begin
                                        st_next[i] = tcps_pkg::ST_ACT;
                                        if (tcps_pkg::ENT_COMPORT[i]) trig = 1'b1;
                                    end else if (st_reg[i] == tcps_pkg::ST_INACT) begin
                                        st_next[i] = tcps_pkg::ST_ACT;
                                        if (tcps_pkg::ENT_COMPORT[i]) begin
                                            snd  = 1'b1;
                                            sv   = tcps_pkg::ENT_YES_SEND[i];
                                            trig = 1'b1;
                                        end
                                    end else if (st_reg[i] == tcps_pkg::ST_REALLY) begin
                                        if (tcps_pkg::ENT_COMPORT[i]) begin
                                            snd = 1'b1;
                                            sv  = tcps_pkg::ENT_NO_SEND[i];
                                        end
                                    end
                                end else if (verb_reg == tcps_pkg::ENT_NO_ACK[i]) begin
                                    if (st_reg[i] == tcps_pkg::ST_REQ) begin
                                        st_next[i] = tcps_pkg::ST_INACT;
                                    end else if (st_reg[i] == tcps_pkg::ST_ACT) begin
                                        st_next[i] = tcps_pkg::ST_INACT;
                                        if (tcps_pkg::ENT_COMPORT[i]) begin
                                            snd = 1'b1;
                                            sv  = tcps_pkg::ENT_NO_SEND[i];
                                        end
                                    end
                                end
                            end
                        end
                        if (!known) begin
                            if (verb_reg == tcps_pkg::B_WILL) begin
                                snd = 1'b1;
                                sv  = tcps_pkg::B_DONT;
                            end else if (verb_reg == tcps_pkg::B_DO) begin
                                snd = 1'b1;
                                sv  = tcps_pkg::B_WONT;
                            end
                        end
                        cap_next   = cap_reg | trig;
                        job.kind   = tcps_pkg::JOB_NEG;
                        job.b0     = c;
                        job.verb   = sv;
                        job.send3  = snd;
                        job.cap_ev = trig && !cap_reg;
                        push       = snd || (trig && !cap_reg);
                    end
                    default: begin
                        mode_next = tcps_pkg::MODE_NORMAL;
                        if (c == tcps_pkg::B_IAC) begin
                            mode_next = tcps_pkg::MODE_IAC;
                        end else begin
                            take = 1'b1;
                        end
                    end
                endcase
                if (take) begin
                    if (coll_reg) begin
                        if (cnt_reg < CNT_W'(SUB_DEPTH)) begin
                            for (int i = 0; i < tcps_pkg::NUM_BUF; i++) begin
                                if (cnt_reg == CNT_W'(i)) buf_next[i] = c;
                            end
                            cnt_next = cnt_reg + 1'b1;
                        end else begin
                            coll_next = 1'b0;
                            cnt_next  = '0;
                        end
                    end else begin
                        job.kind = tcps_pkg::JOB_DATA;
                        job.b0   = c;
                        push     = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= tcps_pkg::MODE_NORMAL;
            coll_reg <= 1'b0;
            cnt_reg  <= '0;
            cap_reg  <= 1'b0;
            verb_reg <= '0;
            for (int i = 0; i < tcps_pkg::NUM_BUF; i++) begin
                buf_reg[i] <= '0;
            end
            for (int i = 0; i < tcps_pkg::NUM_ENTRIES; i++) begin
                st_reg[i] <= tcps_pkg::ENT_INIT[i];
            end
        end else begin
            mode_reg <= mode_next;
            coll_reg <= coll_next;
            cnt_reg  <= cnt_next;
            cap_reg  <= cap_next;
            st_reg   <= st_next;
            buf_reg  <= buf_next;
            verb_reg <= verb_next;
        end
    end

endmodule

// File: rtl/tcps_queue.sv
// ----------------------------------------------------------------------------
// tcps_queue
// Small first-in first-out job queue between parser and reply sequencer.
// ----------------------------------------------------------------------------
module tcps_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tcps_pkg::job_t wr_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output tcps_pkg::job_t head
);

    localparam int AW = $clog2(tcps_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(tcps_pkg::QUEUE_DEPTH + 1);

    tcps_pkg::job_t mem_reg [tcps_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  wr_reg, wr_next;
    logic [AW-1:0]  rd_reg, rd_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full       = (cnt_reg == CW'(tcps_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_reg];

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= wr_job;
        end
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/tcps_back.sv
// ----------------------------------------------------------------------------
// tcps_back
// Expands queued jobs into result beats, one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module tcps_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           head_valid,
    input  tcps_pkg::job_t head,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output tcps_pkg::out_t m_data
);

    tcps_pkg::back_state_t st_reg, st_next, cs, ns;
    tcps_pkg::job_t        job_reg, cj;
    logic                  busy_reg, busy_next;
    logic [1:0]            cnt_reg, cc, nc;
    logic                  esc_reg, ce, ne;
    logic                  sec_reg, c2, n2;
    logic                  mv_reg, mv_next;
    tcps_pkg::out_t        md_reg, beat;
    logic [7:0]            d;
    logic [1:0]            dlast;
    logic                  adv;

    always_comb begin
        if (busy_reg) begin
            cj = job_reg;
            cs = st_reg;
            cc = cnt_reg;
            ce = esc_reg;
            c2 = sec_reg;
        end else begin
            cj = head;
            cc = '0;
            ce = 1'b0;
            c2 = 1'b0;
            unique case (head.kind)
                tcps_pkg::JOB_NEG: cs = head.send3 ? tcps_pkg::BK_OPT : tcps_pkg::BK_CAP;
                tcps_pkg::JOB_SUB: cs = (head.sub == tcps_pkg::SUB_BAUD
                                      || head.sub == tcps_pkg::SUB_CTRL)
                                      ? tcps_pkg::BK_EV : tcps_pkg::BK_HDR;
                default:           cs = tcps_pkg::BK_SERIAL;
            endcase
        end
    end

    assign d     = cj.data[cc];
    assign dlast = (cj.sub == tcps_pkg::SUB_BAUD) ? 2'd3 : 2'd0;

    always_comb begin
        ns = cs;
        nc = cc;
        ne = ce;
        n2 = c2;
        unique case (cs)
            tcps_pkg::BK_OPT: begin
                if (cc == 2'd2) begin
                    ns = tcps_pkg::BK_CAP;
                    nc = '0;
                end else begin
                    nc = cc + 1'b1;
                end
            end
            tcps_pkg::BK_EV: begin
                ns = tcps_pkg::BK_HDR;
                nc = '0;
                if (cj.sub == tcps_pkg::SUB_PURGE) n2 = 1'b1;
            end
            tcps_pkg::BK_HDR: begin
                if (cc == 2'd3) begin
                    ns = tcps_pkg::BK_DATA;
                    nc = '0;
                end else begin
                    nc = cc + 1'b1;
                end
            end
            tcps_pkg::BK_DATA: begin
                if (d == tcps_pkg::B_IAC && !ce) begin
                    ne = 1'b1;
                end else begin
                    ne = 1'b0;
                    if (cc == dlast) begin
                        ns = tcps_pkg::BK_TAIL;
                        nc = '0;
                    end else begin
                        nc = cc + 1'b1;
                    end
                end
            end
            tcps_pkg::BK_TAIL: begin
                if (cc == 2'd0) begin
                    nc = 2'd1;
                end else begin
                    ns = tcps_pkg::BK_EV;
                    nc = '0;
                end
            end
            default: begin
                ns = cs;
            end
        endcase
    end

    always_comb begin
        beat = '0;
        unique case (cs)
            tcps_pkg::BK_OPT: begin
                beat.out_kind = tcps_pkg::OUT_REPLY;
                beat.out_byte = (cc == 2'd0) ? tcps_pkg::B_IAC
                              : (cc == 2'd1) ? cj.verb : cj.b0;
                beat.last     = (cc == 2'd2) && !cj.cap_ev;
            end
            tcps_pkg::BK_CAP: begin
                beat.out_kind   = tcps_pkg::OUT_EVENT;
                beat.event_code = tcps_pkg::EV_CAPABLE;
                beat.last       = 1'b1;
            end
            tcps_pkg::BK_EV: begin
                beat.out_kind = tcps_pkg::OUT_EVENT;
                if (cj.sub == tcps_pkg::SUB_BAUD) begin
                    beat.event_code  = tcps_pkg::EV_BAUD;
                    beat.event_value = {cj.data[0], cj.data[1], cj.data[2], cj.data[3]};
                end else begin
                    beat.event_code  = (cj.sub == tcps_pkg::SUB_PURGE)
                                     ? tcps_pkg::EV_PURGE : tcps_pkg::EV_CONTROL;
                    beat.event_value = {24'd0, cj.data[0]};
                end
            end
            tcps_pkg::BK_HDR: begin
                beat.out_kind = tcps_pkg::OUT_REPLY;
                unique case (cc)
                    2'd0:    beat.out_byte = tcps_pkg::B_IAC;
                    2'd1:    beat.out_byte = tcps_pkg::B_SB;
                    2'd2:    beat.out_byte = tcps_pkg::B_COMPORT;
                    default: beat.out_byte = cj.b0;
                endcase
            end
            tcps_pkg::BK_DATA: begin
                beat.out_kind = tcps_pkg::OUT_REPLY;
                beat.out_byte = (d == tcps_pkg::B_IAC && !ce) ? tcps_pkg::B_IAC : d;
            end
            tcps_pkg::BK_TAIL: begin
                beat.out_kind = tcps_pkg::OUT_REPLY;
                beat.out_byte = (cc == 2'd0) ? tcps_pkg::B_IAC : tcps_pkg::B_SE;
                beat.last     = (cc == 2'd1) && (cj.sub != tcps_pkg::SUB_PURGE || c2);
            end
            default: begin
                beat.out_kind = tcps_pkg::OUT_DATA;
                beat.out_byte = cj.b0;
                beat.last     = 1'b1;
            end
        endcase
    end

    assign adv     = (busy_reg || head_valid) && (!mv_reg || m_ready);
    assign pop     = adv && !busy_reg;
    assign m_valid = mv_reg;
    assign m_data  = md_reg;

    always_comb begin
        busy_next = busy_reg;
        st_next   = st_reg;
        mv_next   = mv_reg && !m_ready;
        if (adv) begin
            mv_next   = 1'b1;
            busy_next = !beat.last;
            st_next   = ns;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            md_reg  <= beat;
            job_reg <= cj;
            cnt_reg <= nc;
            esc_reg <= ne;
            sec_reg <= n2;
        end
        if (!aresetn) begin
            busy_reg <= 1'b0;
            mv_reg   <= 1'b0;
            st_reg   <= tcps_pkg::BK_SERIAL;
        end else begin
            busy_reg <= busy_next;
            mv_reg   <= mv_next;
            st_reg   <= st_next;
        end
    end

endmodule

// File: rtl/telnet_com_port_stream_parser.sv
// ----------------------------------------------------------------------------
// telnet_com_port_stream_parser
// Telnet stream parser with option negotiation and com-port replies.
// ----------------------------------------------------------------------------
// One network byte is taken per cycle while the job queue is not full.
// Plain bytes leave as one beat each, one per cycle unless m_ready stalls.
// A telnet command that needs replies expands into up to seventeen beats,
// produced by the reply sequencer at one beat per cycle unless m_ready stalls;
// the four-entry job queue between parser and sequencer sets how long input
// keeps taking bytes as a burst drains, then stalls until an entry frees up.
module telnet_com_port_stream_parser #(
    parameter int SUB_DEPTH = tcps_pkg::SUB_DEPTH_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tcps_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tcps_pkg::out_t m_data
);

    logic           q_full;
    logic           push;
    logic           pop;
    logic           head_valid;
    tcps_pkg::job_t wr_job;
    tcps_pkg::job_t head;

    tcps_front #(
        .SUB_DEPTH(SUB_DEPTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .push    (push),
        .job     (wr_job)
    );

    tcps_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .wr_job     (wr_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    tcps_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the telnet com-port stream parser. A directed
// table covers plain data, IAC doubling, option negotiation, com-port
// subnegotiations, buffer overflow and session restart. Random telnet traffic
// follows. Every result beat is compared with a built-in parser model.
// ----------------------------------------------------------------------------
module tb;
    import tcps_pkg::*;

    localparam int LIMIT = 400000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    telnet_com_port_stream_parser i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    typedef struct {
        in_t  item;
        bit   check_fixed;
        out_t fixed;
    } row_t;

    mode_t      mdl_mode;
    bit         mdl_collect;
    logic [7:0] mdl_verb;
    logic [7:0] mdl_buf [SUB_DEPTH_DEFAULT];
    int         mdl_count;
    logic [1:0] mdl_opt [NUM_ENTRIES];
    bit         mdl_capable;
    out_t       burst [$];
    out_t       expected_beats [$];
    in_t        stim [$];
    row_t       rows [$];
    int         errors;
    int         cycles;
    int         beats_seen;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic out_t mk(logic [1:0] k, logic [7:0] b, logic [2:0] c, logic [31:0] v);
        out_t o;
        o.out_kind = k;
        o.out_byte = b;
        o.event_code = c;
        o.event_value = v;
        o.last = 1'b0;
        return o;
    endfunction

    task automatic put_reply(logic [7:0] b);
        if (burst.size() < 17) burst.push_back(mk(OUT_REPLY, b, EV_NONE, 32'd0));
    endtask

    task automatic put_event(logic [2:0] c, logic [31:0] v);
        if (burst.size() < 17) burst.push_back(mk(OUT_EVENT, 8'h00, c, v));
    endtask

    task automatic put_option(logic [7:0] verb, logic [7:0] opt);
        put_reply(B_IAC);
        put_reply(verb);
        put_reply(opt);
    endtask

    task automatic mark_capable();
        if (!mdl_capable) begin
            mdl_capable = 1'b1;
            put_event(EV_CAPABLE, 32'd0);
        end
    endtask

    task automatic session_restart();
        mdl_mode = MODE_NORMAL;
        mdl_collect = 1'b0;
        mdl_count = 0;
        mdl_capable = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++) mdl_opt[i] = ENT_INIT[i];
    endtask

    task automatic plain_byte(logic [7:0] c);
        if (mdl_collect) begin
            if (mdl_count < SUB_DEPTH_DEFAULT) begin
                mdl_buf[mdl_count] = c;
                mdl_count++;
            end else begin
                mdl_collect = 1'b0;
                mdl_count = 0;
            end
        end else begin
            burst.push_back(mk(OUT_DATA, c, EV_NONE, 32'd0));
        end
    endtask

    task automatic option_verb(logic [7:0] verb, logic [7:0] opt);
        bit known;
        logic [1:0] s;
        known = 1'b0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (ENT_OPT[i] == opt) begin
                known = 1'b1;
                s = mdl_opt[i];
                if (verb == ENT_YES_ACK[i]) begin
                    if (s == ST_REQ) begin
                        mdl_opt[i] = ST_ACT;
                        if (ENT_COMPORT[i]) mark_capable();
                    end else if (s == ST_INACT) begin
                        mdl_opt[i] = ST_ACT;
                        if (ENT_COMPORT[i]) begin
                            put_option(ENT_YES_SEND[i], opt);
                            mark_capable();
                        end
                    end else if (s == ST_REALLY) begin
                        if (ENT_COMPORT[i]) put_option(ENT_NO_SEND[i], opt);
                    end
                end else if (verb == ENT_NO_ACK[i]) begin
                    if (s == ST_REQ) begin
                        mdl_opt[i] = ST_INACT;
                    end else if (s == ST_ACT) begin
                        mdl_opt[i] = ST_INACT;
                        if (ENT_COMPORT[i]) put_option(ENT_NO_SEND[i], opt);
                    end
                end
            end
        end
        if (!known) begin
            if (verb == B_WILL) put_option(B_DONT, opt);
            if (verb == B_DO) put_option(B_WONT, opt);
        end
    endtask

    task automatic framed_reply(logic [7:0] cmd, int n);
        put_reply(B_IAC);
        put_reply(B_SB);
        put_reply(B_COMPORT);
        put_reply(cmd);
        for (int i = 0; i < n; i++) begin
            if (mdl_buf[2 + i] == B_IAC) put_reply(B_IAC);
            put_reply(mdl_buf[2 + i]);
        end
        put_reply(B_IAC);
        put_reply(B_SE);
    endtask

    task automatic comport_request();
        logic [7:0] cmd;
        if (mdl_buf[0] != B_COMPORT) return;
        cmd = mdl_buf[1];
        if (cmd == CMD_BAUD) begin
            put_event(EV_BAUD, {mdl_buf[2], mdl_buf[3], mdl_buf[4], mdl_buf[5]});
            framed_reply(RPL_BAUD, 4);
        end else if (cmd == CMD_CONTROL) begin
            put_event(EV_CONTROL, {24'h0, mdl_buf[2]});
            framed_reply(RPL_CONTROL, 1);
        end else if (cmd == CMD_PURGE) begin
            framed_reply(RPL_PURGE, 1);
            put_event(EV_PURGE, {24'h0, mdl_buf[2]});
            framed_reply(RPL_PURGE, 1);
        end else if (cmd == CMD_DATA || cmd == CMD_PARITY || cmd == CMD_STOP
                     || cmd == CMD_NOTIFY || cmd == CMD_MASK) begin
            framed_reply(RPL_BASE + cmd, 1);
        end
    endtask

    // Advances the parser model by one input beat and returns its result beats.
    task automatic parse_beat(in_t it);
        logic [7:0] c;
        c = it.in_byte;
        burst.delete();
        if (it.op) begin
            session_restart();
            return;
        end
        if (mdl_mode == MODE_IAC) begin
            mdl_mode = MODE_NORMAL;
            if (c == B_IAC) begin
                plain_byte(c);
            end else if (c == B_SB) begin
                mdl_count = 0;
                mdl_collect = 1'b1;
            end else if (c == B_SE) begin
                comport_request();
                mdl_count = 0;
                mdl_collect = 1'b0;
            end else if (c == B_WILL || c == B_WONT || c == B_DO || c == B_DONT) begin
                mdl_verb = c;
                mdl_mode = MODE_NEG;
            end
        end else if (mdl_mode == MODE_NEG) begin
            mdl_mode = MODE_NORMAL;
            option_verb(mdl_verb, c);
        end else begin
            if (c == B_IAC) mdl_mode = MODE_IAC;
            else plain_byte(c);
        end
        if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    endtask

    function automatic in_t nb(logic [7:0] b);
        in_t it;
        it.op = 1'b0;
        it.in_byte = b;
        return it;
    endfunction

    task automatic add_row(logic [7:0] b, bit chk, out_t f);
        row_t r;
        r.item = nb(b);
        r.check_fixed = chk;
        r.fixed = f;
        rows.push_back(r);
    endtask

    task automatic add_seq(logic [7:0] s [$]);
        foreach (s[i]) stim.push_back(nb(s[i]));
    endtask

    // Builds one telnet exchange with random content, not always well-formed.
    task automatic random_exchange();
        logic [7:0] s [$];
        logic [7:0] vb [4];
        logic [7:0] opts [5];
        int k;
        int n;
        vb = '{B_WILL, B_WONT, B_DO, B_DONT};
        opts = '{8'h00, 8'h01, 8'h03, B_COMPORT, 8'h00};
        k = $urandom_range(0, 9);
        if (k < 3) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) s.push_back(8'($urandom_range(0, 254)));
        end else if (k < 5) begin
            s = '{B_IAC, vb[$urandom_range(0, 3)], 8'h00};
            s[2] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : opts[$urandom_range(0, 3)];
        end else if (k < 8) begin
            logic [7:0] cmds [9];
            cmds = '{CMD_BAUD, CMD_DATA, CMD_PARITY, CMD_STOP, CMD_CONTROL, CMD_NOTIFY,
                     CMD_MASK, CMD_PURGE, 8'h00};
            s = '{B_IAC, B_SB, B_COMPORT};
            s.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : cmds[$urandom_range(0, 8)]);
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    s.push_back(B_IAC);
                    s.push_back(B_IAC);
                end else begin
                    s.push_back(8'($urandom));
                    if (s[s.size() - 1] == B_IAC) s.push_back(B_IAC);
                end
            end
            s.push_back(B_IAC);
            s.push_back(B_SE);
        end else if (k == 8) begin
            s = '{B_IAC, 8'h00};
            s[1] = 8'($urandom);
        end else begin
            if ($urandom_range(0, 5) == 0) begin
                in_t it;
                it.op = 1'b1;
                it.in_byte = 8'($urandom);
                stim.push_back(it);
            end else begin
                s.push_back(8'($urandom));
            end
        end
        add_seq(s);
    endtask

    // Sender: bursts of beats with random gaps; predicts each accepted beat.
    initial begin
        int idx;
        int gap;
        int run;
        out_t z;
        row_t r;
        in_t rst;
        errors = 0;
        cycles = 0;
        beats_seen = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        for (int i = 0; i < SUB_DEPTH_DEFAULT; i++) mdl_buf[i] = 8'h00;
        mdl_verb = 8'h00;
        session_restart();
        z = mk(OUT_DATA, 8'h00, EV_NONE, 32'd0);
        z.last = 1'b1;
        add_row(8'h00, 1'b1, z);
        z.out_byte = 8'hfe;
        add_row(8'hfe, 1'b1, z);
        add_row(B_IAC, 1'b0, z);
        z.out_byte = 8'hff;
        add_row(B_IAC, 1'b1, z);
        add_row(B_IAC, 1'b0, z);
        add_row(B_DO, 1'b0, z);
        add_row(B_COMPORT, 1'b0, z);
        add_row(B_IAC, 1'b0, z);
        add_row(B_WILL, 1'b0, z);
        add_row(B_COMPORT, 1'b0, z);
        add_row(B_IAC, 1'b0, z);
        add_row(B_WILL, 1'b0, z);
        add_row(8'h55, 1'b0, z);
        add_row(B_IAC, 1'b0, z);
        add_row(B_DONT, 1'b0, z);
        add_row(B_COMPORT, 1'b0, z);
        add_row(B_IAC, 1'b0, z);
        add_row(8'hf1, 1'b0, z);
        add_row(B_IAC, 1'b0, z);
        z = mk(OUT_EVENT, 8'h00, EV_NONE, 32'd0);
        add_row(B_SE, 1'b0, z);
        foreach (rows[i]) stim.push_back(rows[i].item);
        add_seq('{B_IAC, B_SB, B_COMPORT, CMD_BAUD, 8'hff, 8'hff, 8'h00, 8'h80, B_IAC, B_SE});
        add_seq('{B_IAC, B_SB, B_COMPORT, CMD_PURGE, 8'hff, 8'hff, B_IAC, B_SE});
        add_seq('{B_IAC, B_SB});
        for (int i = 0; i < 18; i++) stim.push_back(nb(8'(8'h41 + i)));
        add_seq('{B_IAC, B_SE});
        rst.op = 1'b1;
        rst.in_byte = 8'hff;
        stim.push_back(rst);
        add_seq('{B_IAC, B_SB, B_COMPORT, CMD_CONTROL, 8'h0b, B_IAC, B_SE});
        while (stim.size() < 320) random_exchange();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idx = 0;
        while (idx < stim.size()) begin
            run = $urandom_range(1, 30);
            while (run > 0 && idx < stim.size()) begin
                s_valid <= 1'b1;
                s_data <= stim[idx];
                @(posedge aclk);
                while (!s_ready) @(posedge aclk);
                parse_beat(stim[idx]);
                if (idx < rows.size() && rows[idx].check_fixed) begin
                    if (burst.size() != 1) begin
                        $error("row %0d: result count expected 1 actual %0d", idx,
                               burst.size());
                        errors++;
                    end else if (burst[0] != rows[idx].fixed) begin
                        $error("row %0d: result expected %p actual %p", idx,
                               rows[idx].fixed, burst[0]);
                        errors++;
                    end
                end
                foreach (burst[j]) expected_beats.push_back(burst[j]);
                idx++;
                run--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 || idx >= stim.size()) s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b0;
        while (expected_beats.size() > 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("Sent %0d input beats, checked %0d result beats.", stim.size(), beats_seen);
        $display("Covered data, IAC escapes, negotiation, com-port requests and overflow.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Receiver: stall pattern plus one long hold-off to back up the block.
    initial begin
        int k;
        m_ready = 1'b0;
        k = 0;
        @(posedge aclk iff aresetn);
        repeat (60) @(posedge aclk);
        m_ready <= 1'b0;
        repeat (150) @(posedge aclk);
        forever begin
            k++;
            if ((k / 64) % 3 == 0) m_ready <= 1'b1;
            else m_ready <= ((k % 7) < 4) || ($urandom_range(0, 3) == 0);
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        out_t e;
        if (aresetn && m_valid && m_ready) begin
            beats_seen <= beats_seen + 1;
            if (expected_beats.size() == 0) begin
                $error("result beat with none expected: %p", m_data);
                errors++;
            end else begin
                e = expected_beats.pop_front();
                if (m_data.out_kind !== e.out_kind) begin
                    $error("out_kind expected %0d actual %0d", e.out_kind, m_data.out_kind);
                    errors++;
                end
                if (m_data.out_byte !== e.out_byte) begin
                    $error("out_byte expected %h actual %h", e.out_byte, m_data.out_byte);
                    errors++;
                end
                if (m_data.event_code !== e.event_code) begin
                    $error("event_code expected %0d actual %0d", e.event_code,
                           m_data.event_code);
                    errors++;
                end
                if (m_data.event_value !== e.event_value) begin
                    $error("event_value expected %h actual %h", e.event_value,
                           m_data.event_value);
                    errors++;
                end
                if (m_data.last !== e.last) begin
                    $error("last expected %b actual %b", e.last, m_data.last);
                    errors++;
                end
            end
        end
    end

endmodule
